@@ rtl/u8v_pkg.sv @@
// Package for the UTF-8 validator: state types, byte constants and the
// continuation range check. Used by u8v_check and utf8_validator.
// No dependencies.
package u8v_pkg;

  localparam logic [7:0] AsciiMax  = 8'h7E;
  localparam logic [7:0] DelByte   = 8'h7F;
  localparam logic [7:0] Lead2Min  = 8'hC2;
  localparam logic [7:0] Lead2Max  = 8'hDF;
  localparam logic [7:0] LeadE0    = 8'hE0;
  localparam logic [7:0] LeadED    = 8'hED;
  localparam logic [7:0] Lead3Max  = 8'hEF;
  localparam logic [7:0] LeadF0    = 8'hF0;
  localparam logic [7:0] LeadF4    = 8'hF4;
  localparam logic [7:0] ContMin   = 8'h80;
  localparam logic [7:0] ContMax   = 8'hBF;
  localparam logic [7:0] ContE0Min = 8'hA0;
  localparam logic [7:0] ContEDMax = 8'h9F;
  localparam logic [7:0] ContF0Min = 8'h90;
  localparam logic [7:0] ContF4Max = 8'h8F;

  // Allowed range of the next continuation byte.
  typedef enum logic [2:0] {
    KIND_ANY = 3'd0,
    KIND_E0  = 3'd1,
    KIND_ED  = 3'd2,
    KIND_F0  = 3'd3,
    KIND_F4  = 3'd4
  } kind_e;

  typedef struct packed {
    logic [1:0] pending;
    kind_e      kind;
    logic       error;
  } state_t;

  localparam state_t StateClear = '{pending: 2'd0, kind: KIND_ANY, error: 1'b0};

  function automatic logic cont_ok(input logic [7:0] b, input kind_e kind);
    logic ok;
    case (kind)
      KIND_E0: ok = b inside {[ContE0Min:ContMax]};
      KIND_ED: ok = b inside {[ContMin:ContEDMax]};
      KIND_F0: ok = b inside {[ContF0Min:ContMax]};
      KIND_F4: ok = b inside {[ContMin:ContF4Max]};
      default: ok = b inside {[ContMin:ContMax]};
    endcase
    return ok;
  endfunction

endpackage

@@ rtl/utf8_validator.sv @@
// UTF-8 validator top level: input register, byte check and result register.
// Depends on u8v_pkg and u8v_check.
// A byte marked last passes the input register, then the result register.
// Throughput: one byte per cycle; the input stage stalls only when a result
// waits in the output register and the next byte held is itself a last byte.
// Reset clears the sequence state, both stages and accept_del (to zero).
module utf8_validator import u8v_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       valid_res_o
);

  logic       accept_del_q;
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  state_t     state_q, state_d;
  logic       out_valid_q;
  logic       res_q, res_d;
  logic       out_free;
  logic       s1_adv;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accept_del_q <= 1'b0;
    end else if (cfg_valid_i) begin
      accept_del_q <= cfg_data_i;
    end
  end

  // A byte that is not last produces no result, so it never waits on the
  // output register.
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && (!s1_last_q || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  u8v_check u_check (
    .data_byte_i (s1_byte_q),
    .last_byte_i (s1_last_q),
    .accept_del_i(accept_del_q),
    .state_i     (state_q),
    .state_o     (state_d),
    .valid_res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateClear;
    end else if (s1_adv) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign valid_res_o = res_q;

endmodule

@@ rtl/u8v_check.sv @@
// Combinational byte check of the UTF-8 validator: next sequence state and
// the string verdict for one byte. Depends on u8v_pkg.
module u8v_check import u8v_pkg::*; (
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       accept_del_i,
  input  state_t     state_i,
  output state_t     state_o,
  output logic       valid_res_o
);

  state_t upd;

  always_comb begin
    upd = state_i;
    // Once an error is seen the rest of the string is not inspected.
    if (!state_i.error) begin
      if (state_i.pending != 2'd0) begin
        if (cont_ok(data_byte_i, state_i.kind)) begin
          upd.pending = state_i.pending - 2'd1;
          upd.kind    = KIND_ANY;
        end else begin
          upd.error = 1'b1;
        end
      end else begin
        upd.kind = KIND_ANY;
        if (data_byte_i <= AsciiMax) begin
          upd.error = 1'b0;
        end else if (data_byte_i == DelByte) begin
          upd.error = !accept_del_i;
        end else if (data_byte_i inside {[Lead2Min:Lead2Max]}) begin
          upd.pending = 2'd1;
        end else if (data_byte_i inside {[LeadE0:Lead3Max]}) begin
          upd.pending = 2'd2;
          if (data_byte_i == LeadE0) begin
            upd.kind = KIND_E0;
          end else if (data_byte_i == LeadED) begin
            upd.kind = KIND_ED;
          end
        end else if (data_byte_i inside {[LeadF0:LeadF4]}) begin
          upd.pending = 2'd3;
          if (data_byte_i == LeadF0) begin
            upd.kind = KIND_F0;
          end else if (data_byte_i == LeadF4) begin
            upd.kind = KIND_F4;
          end
        end else begin
          upd.error = 1'b1;
        end
      end
    end
  end

  assign valid_res_o = !upd.error && (upd.pending == 2'd0);
  assign state_o     = last_byte_i ? StateClear : upd;

endmodule

@@ rtl/u8v_checker.sv @@
// Port-level assertions for the UTF-8 validator, bound to utf8_validator.
// Depends on the top level's port list only.
module u8v_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] data_byte_i,
  input logic       last_byte_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       valid_res_o
);

  logic in_last_acc;
  assign in_last_acc = in_valid_i && in_ready_o && last_byte_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(valid_res_o))
    else $error("result changed or dropped while stalled");

  // A fresh result must follow from an accepted last item.
  a_res_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_last_acc, 2))
    else $error("result without a last item two cycles before");

  // A string ending on a lead byte or an invalid byte is never well-formed.
  a_open_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && $past(in_last_acc && (data_byte_i >= 8'hC0), 2)
    |-> !valid_res_o)
    else $error("string ending on a lead byte reported valid");

  // Bytes keep flowing whenever the output side is not stalled.
  a_no_bubble: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && !out_ready_i) |-> in_ready_o)
    else $error("input stalled while the output was free");

endmodule

bind utf8_validator u8v_checker u_checker (.*);
